### hdl/clp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the polygon window clipper.
// No dependencies; imported by every module of the block.
package clp_pkg;

   localparam int WINDOW_EDGES = 4;
   localparam int NUM_CSR      = 2 * WINDOW_EDGES;
   localparam int CSR_AW       = 3;

   // corner register indexes
   typedef enum logic [CSR_AW-1:0] {
      CSR_CORNER0_X = 3'd0,
      CSR_CORNER0_Y = 3'd1,
      CSR_CORNER1_X = 3'd2,
      CSR_CORNER1_Y = 3'd3,
      CSR_CORNER2_X = 3'd4,
      CSR_CORNER2_Y = 3'd5,
      CSR_CORNER3_X = 3'd6,
      CSR_CORNER3_Y = 3'd7
   } csr_index_type;

   localparam int CORNER_RESET [NUM_CSR] = '{80, 60, 80, 420, 560, 420, 560, 60};

   // what a token between cells carries besides its coordinates
   typedef struct packed {
      logic vtx;    // coordinates are a vertex
      logic last;   // end of polygon follows (after the vertex, if any)
   } tok_flags_type;

endpackage

### hdl/clp_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, unsigned.
// Quotient must fit in QB bits (num < den << QB). Uses clp_pkg.
module clp_div #(
   parameter int NW = 40,
   parameter int DW = 28,
   parameter int QB = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [QB-1:0] quo,
   output logic          rem_nz
);
   import clp_pkg::*;

   localparam int CW = $clog2(QB + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [CW-1:0] cnt_ff;
   logic [DW-1:0] rem_ff;
   logic [DW-1:0] den_ff;
   logic [QB-1:0] sh_ff;
   logic [DW:0]   trial;
   logic [DW:0]   trial_sub;
   logic          ge;

   assign trial     = {rem_ff, sh_ff[QB-1]};
   assign trial_sub = trial - {1'b0, den_ff};
   assign ge        = trial >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= CW'(QB);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= DW'(num[NW-1:QB]);
         sh_ff  <= num[QB-1:0];
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= ge ? trial_sub[DW-1:0] : trial[DW-1:0];
         sh_ff  <= {sh_ff[QB-2:0], ge};
      end
   end

   assign done   = done_ff;
   assign quo    = sh_ff;
   assign rem_nz = rem_ff != '0;

endmodule

### hdl/clp_cell.sv
`timescale 1ns / 1ps
// One clipping cell: clips the vertex stream against the directed edge a->b.
// Keeps first and previous vertex; uses clp_div and clp_pkg.
module clp_cell #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [COORD_BITS-1:0] up_x,
   input  logic signed [COORD_BITS-1:0] up_y,
   input  clp_pkg::tok_flags_type       up_f,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic signed [COORD_BITS-1:0] dn_x,
   output logic signed [COORD_BITS-1:0] dn_y,
   output clp_pkg::tok_flags_type       dn_f
);
   import clp_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int KW = 2 * C + 3;   // cross product
   localparam int DW = 2 * C + 4;   // k1 - k2
   localparam int NW = 3 * C + 4;   // delta * k1
   localparam int QB = C + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_CLS, S_K1, S_K2, S_KD, S_DEC, S_DST, S_DIV, S_CRS, S_PT, S_END
   } state_type;

   state_type state_ff;
   logic      started_ff, last_ff, closing_ff, in2_ff;
   logic signed [C-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;
   logic signed [C-1:0] p1x_ff, p1y_ff, p2x_ff, p2y_ff;
   logic signed [2*C+1:0] pa_ff, pb_ff;
   logic signed [KW-1:0]  k1_ff, k2_ff;
   logic signed [NW-1:0]  nx_ff, ny_ff;
   logic signed [DW-1:0]  d_ff;
   logic                  dn_valid_ff;
   logic signed [C-1:0]   dn_x_ff, dn_y_ff;
   tok_flags_type         dn_f_ff;

   logic signed [C:0]     ex, ey, rel_x, rel_y, dx, dy;
   logic signed [C-1:0]   sel_x, sel_y;
   logic signed [2*C+1:0] pa_in, pb_in;
   logic signed [KW-1:0]  k_in;
   logic [NW-1:0]         nx_mag, ny_mag;
   logic [DW-1:0]         d_mag;
   logic                  div_start, done_x, done_y, rem_x, rem_y, out_free;
   logic [QB-1:0]         q_x, q_y;
   logic signed [C-1:0]   cross_x, cross_y;
   state_type             after_clip;

   // trunc(c1 + n/d) from |n|/|d| quotient and remainder flag
   function automatic logic signed [C-1:0] fix_up(input logic signed [C-1:0] c1,
                                                  input logic [QB-1:0] q,
                                                  input logic rem, input logic neg);
      logic signed [C+1:0] base, qe, fl;
      base = c1;
      qe   = signed'({1'b0, q});
      fl   = neg ? base - qe - signed'((C+2)'(rem)) : base + qe;
      if (rem && fl < 0) fl = fl + 1;
      return fl[C-1:0];
   endfunction

   assign ex    = bx - ax;
   assign ey    = by - ay;
   assign sel_x = (state_ff == S_K1) ? p1x_ff : p2x_ff;
   assign sel_y = (state_ff == S_K1) ? p1y_ff : p2y_ff;
   assign rel_x = sel_x - ax;
   assign rel_y = sel_y - ay;
   assign pa_in = ex * rel_y;
   assign pb_in = ey * rel_x;
   assign k_in  = pa_ff - pb_ff;
   assign dx    = p2x_ff - p1x_ff;
   assign dy    = p2y_ff - p1y_ff;

   assign nx_mag = nx_ff[NW-1] ? NW'(-nx_ff) : NW'(nx_ff);
   assign ny_mag = ny_ff[NW-1] ? NW'(-ny_ff) : NW'(ny_ff);
   assign d_mag  = d_ff[DW-1] ? DW'(-d_ff) : DW'(d_ff);
   assign div_start = state_ff == S_DST;

   clp_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_x (
      .clock(clock), .reset(reset), .start(div_start), .num(nx_mag), .den(d_mag),
      .done(done_x), .quo(q_x), .rem_nz(rem_x)
   );
   clp_div #(.NW(NW), .DW(DW), .QB(QB)) u_div_y (
      .clock(clock), .reset(reset), .start(div_start), .num(ny_mag), .den(d_mag),
      .done(done_y), .quo(q_y), .rem_nz(rem_y)
   );

   assign cross_x = fix_up(p1x_ff, q_x, rem_x, nx_ff[NW-1] ^ d_ff[DW-1]);
   assign cross_y = fix_up(p1y_ff, q_y, rem_y, ny_ff[NW-1] ^ d_ff[DW-1]);

   assign out_free   = !dn_valid_ff || dn_ready;
   assign after_clip = closing_ff ? S_END : (last_ff ? S_CLS : S_IDLE);
   assign up_ready   = state_ff == S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         started_ff  <= 1'b0;
         dn_valid_ff <= 1'b0;
         last_ff     <= 1'b0;
         closing_ff  <= 1'b0;
      end else begin
         if (dn_ready) dn_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (up_valid) begin
                  last_ff    <= up_f.last;
                  closing_ff <= 1'b0;
                  if (up_f.vtx) begin
                     prev_x_ff <= up_x;
                     prev_y_ff <= up_y;
                     if (started_ff) begin
                        p1x_ff   <= prev_x_ff;
                        p1y_ff   <= prev_y_ff;
                        p2x_ff   <= up_x;
                        p2y_ff   <= up_y;
                        state_ff <= S_K1;
                     end else begin
                        first_x_ff <= up_x;
                        first_y_ff <= up_y;
                        started_ff <= 1'b1;
                        state_ff   <= up_f.last ? S_CLS : S_IDLE;
                     end
                  end else begin
                     state_ff <= up_f.last ? S_CLS : S_IDLE;
                  end
               end
            end
            S_CLS: begin
               // close the edge back to the first vertex
               started_ff <= 1'b0;
               closing_ff <= 1'b1;
               p1x_ff     <= prev_x_ff;
               p1y_ff     <= prev_y_ff;
               p2x_ff     <= first_x_ff;
               p2y_ff     <= first_y_ff;
               state_ff   <= started_ff ? S_K1 : S_END;
            end
            S_K1: begin
               pa_ff    <= pa_in;
               pb_ff    <= pb_in;
               state_ff <= S_K2;
            end
            S_K2: begin
               k1_ff    <= k_in;
               pa_ff    <= pa_in;
               pb_ff    <= pb_in;
               state_ff <= S_KD;
            end
            S_KD: begin
               k2_ff    <= k_in;
               state_ff <= S_DEC;
            end
            S_DEC: begin
               in2_ff <= k2_ff[KW-1];
               nx_ff  <= dx * k1_ff;
               ny_ff  <= dy * k1_ff;
               d_ff   <= DW'(k1_ff) - DW'(k2_ff);
               if (k1_ff[KW-1] != k2_ff[KW-1]) state_ff <= S_DST;
               else if (k2_ff[KW-1])           state_ff <= S_PT;
               else                            state_ff <= after_clip;
            end
            S_DST: state_ff <= S_DIV;
            S_DIV: if (done_x && done_y) state_ff <= S_CRS;
            S_CRS: begin
               if (out_free) begin
                  dn_valid_ff <= 1'b1;
                  dn_x_ff     <= cross_x;
                  dn_y_ff     <= cross_y;
                  dn_f_ff     <= '{vtx: 1'b1, last: 1'b0};
                  state_ff    <= in2_ff ? S_PT : after_clip;
               end
            end
            S_PT: begin
               if (out_free) begin
                  dn_valid_ff <= 1'b1;
                  dn_x_ff     <= p2x_ff;
                  dn_y_ff     <= p2y_ff;
                  dn_f_ff     <= '{vtx: 1'b1, last: 1'b0};
                  state_ff    <= after_clip;
               end
            end
            S_END: begin
               if (out_free) begin
                  dn_valid_ff <= 1'b1;
                  dn_x_ff     <= '0;
                  dn_y_ff     <= '0;
                  dn_f_ff     <= '{vtx: 1'b0, last: 1'b1};
                  state_ff    <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign dn_valid = dn_valid_ff;
   assign dn_x     = dn_x_ff;
   assign dn_y     = dn_y_ff;
   assign dn_f     = dn_f_ff;

endmodule

### hdl/clp_sink.sv
`timescale 1ns / 1ps
// Output stage: holds back one vertex so the last one can carry the end mark,
// and reports an empty polygon. Uses clp_pkg.
module clp_sink #(
   parameter int COORD_BITS = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [COORD_BITS-1:0] up_x,
   input  logic signed [COORD_BITS-1:0] up_y,
   input  clp_pkg::tok_flags_type       up_f,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic signed [COORD_BITS-1:0] out_x,
   output logic signed [COORD_BITS-1:0] out_y,
   output logic                         out_end,
   output logic                         out_empty
);
   import clp_pkg::*;

   logic                         held_valid_ff, out_valid_ff, out_end_ff, out_empty_ff;
   logic signed [COORD_BITS-1:0] held_x_ff, held_y_ff, out_x_ff, out_y_ff;
   logic                         take;

   assign up_ready = !out_valid_ff || out_ready;
   assign take     = up_valid && up_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (out_ready) out_valid_ff <= 1'b0;
         if (take) begin
            if (up_f.vtx) begin
               if (held_valid_ff) begin
                  out_valid_ff <= 1'b1;
                  out_x_ff     <= held_x_ff;
                  out_y_ff     <= held_y_ff;
                  out_end_ff   <= 1'b0;
                  out_empty_ff <= 1'b0;
               end
               held_valid_ff <= 1'b1;
               held_x_ff     <= up_x;
               held_y_ff     <= up_y;
            end else if (up_f.last) begin
               out_valid_ff  <= 1'b1;
               out_x_ff      <= held_valid_ff ? held_x_ff : '0;
               out_y_ff      <= held_valid_ff ? held_y_ff : '0;
               out_end_ff    <= 1'b1;
               out_empty_ff  <= !held_valid_ff;
               held_valid_ff <= 1'b0;
            end
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign out_end   = out_end_ff;
   assign out_empty = out_empty_ff;

endmodule

### hdl/polygon_window_clipper.sv
`timescale 1ns / 1ps
// Polygon window clipper: four clipping cells in a row, then the output stage.
// A cell takes longer on a vertex that it passes on, and longer still when a crossing
// must be found: the restoring divider gives one quotient bit a cycle. A final vertex
// adds one closing edge per cell. Cells overlap, so throughput is set by the slowest
// cell; each cell takes a new vertex only when it is back in its idle state.
// Synchronous active-high reset clears all cells and restores the default window.
module polygon_window_clipper #(
   parameter int COORD_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((2*COORD_BITS+7)/8)*8-1:0]     req_tdata,  // vertex_x, vertex_y
   input  logic                                  req_tlast,  // final_vertex
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((2*COORD_BITS+7)/8)*8-1:0]     rsp_tdata,  // clip_x, clip_y
   output logic                                  rsp_tlast,  // end_of_polygon
   output logic                                  rsp_tuser,  // nothing_left
   input  logic                                  csr_we,
   input  logic [clp_pkg::CSR_AW-1:0]            csr_addr,
   input  logic [COORD_BITS-1:0]                 csr_wdata
);
   import clp_pkg::*;

   localparam int C  = COORD_BITS;
   localparam int TW = ((2 * C + 7) / 8) * 8;

   logic signed [C-1:0] corner_ff [NUM_CSR];

   logic                ch_valid [WINDOW_EDGES+1];
   logic                ch_ready [WINDOW_EDGES+1];
   logic signed [C-1:0] ch_x     [WINDOW_EDGES+1];
   logic signed [C-1:0] ch_y     [WINDOW_EDGES+1];
   tok_flags_type       ch_f     [WINDOW_EDGES+1];
   logic signed [C-1:0] out_x, out_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CSR; i++) corner_ff[i] <= C'(CORNER_RESET[i]);
      end else if (csr_we) begin
         corner_ff[csr_addr] <= csr_wdata;
      end
   end

   assign ch_valid[0] = req_tvalid;
   assign req_tready  = ch_ready[0];
   assign ch_x[0]     = req_tdata[C-1:0];
   assign ch_y[0]     = req_tdata[2*C-1:C];
   assign ch_f[0]     = '{vtx: 1'b1, last: req_tlast};

   for (genvar s = 0; s < WINDOW_EDGES; s++) begin : g_cell
      localparam int J = (s + 1) % WINDOW_EDGES;
      clp_cell #(.COORD_BITS(C)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .ax      (corner_ff[2*s]),
         .ay      (corner_ff[2*s+1]),
         .bx      (corner_ff[2*J]),
         .by      (corner_ff[2*J+1]),
         .up_valid(ch_valid[s]),
         .up_ready(ch_ready[s]),
         .up_x    (ch_x[s]),
         .up_y    (ch_y[s]),
         .up_f    (ch_f[s]),
         .dn_valid(ch_valid[s+1]),
         .dn_ready(ch_ready[s+1]),
         .dn_x    (ch_x[s+1]),
         .dn_y    (ch_y[s+1]),
         .dn_f    (ch_f[s+1])
      );
   end

   clp_sink #(.COORD_BITS(C)) u_sink (
      .clock    (clock),
      .reset    (reset),
      .up_valid (ch_valid[WINDOW_EDGES]),
      .up_ready (ch_ready[WINDOW_EDGES]),
      .up_x     (ch_x[WINDOW_EDGES]),
      .up_y     (ch_y[WINDOW_EDGES]),
      .up_f     (ch_f[WINDOW_EDGES]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_x    (out_x),
      .out_y    (out_y),
      .out_end  (rsp_tlast),
      .out_empty(rsp_tuser)
   );

   assign rsp_tdata = TW'({out_y, out_x});

endmodule

### hdl/clp_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the clipper.
// Bound to polygon_window_clipper below; uses clp_pkg.
module clp_checker #(
   parameter int COORD_BITS = 12
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [((2*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              rsp_tuser
);
   import clp_pkg::*;

   // an empty polygon result is always the end of that polygon
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("empty result without end mark");

   // an empty polygon result has zeroed coordinates
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("empty result with nonzero coordinates");

   // nothing comes out right after reset
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled item stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                     && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

endmodule

bind polygon_window_clipper clp_checker #(.COORD_BITS(COORD_BITS)) u_clp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast),
   .rsp_tuser (rsp_tuser)
);
